/* sv/cltrig_pkg.sv */
// package for the clutch trigger block: widths, register codes and reset values,
// configuration and result record types
// no dependencies
`default_nettype none

package cltrig_pkg;

  localparam int MAX_CH       = 8;
  localparam int CHANNELS_DEF = 8;
  localparam int POS_BITS_DEF = 24;
  localparam int VEL_W        = 8;
  localparam int POS_OUT_W    = 24;
  localparam int CFG_DATA_W   = 24;
  localparam int CFG_IDX_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REV_FLOOR  = 3'd0,
    CFG_ENG_DEPTH  = 3'd1,
    CFG_ENG_SPEED  = 3'd2,
    CFG_REL_SPEED  = 3'd3,
    CFG_DRIVE_MASK = 3'd4
  } cfg_idx_t;

  localparam logic [23:0] REV_FLOOR_RST  = 24'hFFFFCE;  // -50
  localparam logic [23:0] ENG_DEPTH_RST  = 24'hFFFFC4;  // -60
  localparam logic [7:0]  ENG_SPEED_RST  = 8'hFA;       // -6
  localparam logic [7:0]  REL_SPEED_RST  = 8'hFB;       // -5
  localparam logic [7:0]  DRIVE_MASK_RST = 8'hFC;

  typedef struct packed {
    logic [23:0]       rev_floor;
    logic [23:0]       eng_depth;
    logic [7:0]        eng_speed;
    logic [7:0]        rel_speed;
    logic [MAX_CH-1:0] drive_mask;
  } cfg_t;

  typedef struct packed {
    logic [MAX_CH-1:0]                drive;
    logic [MAX_CH-1:0]                latched;
    logic [MAX_CH-1:0][POS_OUT_W-1:0] pos;
  } res_t;

endpackage

`default_nettype wire

/* sv/clutch_trigger_from_leg_motion_top.sv */
// top level of the clutch trigger block: row of channel cells, register bank,
// result register with skid stage; depends on cltrig_pkg, cltrig_cfg, cltrig_cell
//
// usage:
//   item channel (item_valid/item_ready) carries run and one signed sample per
//   channel; result channel (result_valid/result_ready) returns the drive and
//   latch masks and every channel position after that request
//   every request gives exactly one result; while the receiver stalls it may wait in the skid stage
//   throughput is one request per cycle while the skid stage is empty; all channels
//   work in parallel in their own cell and each cell updates its state in the
//   accepting cycle; a result register plus a one-deep skid stage sit on the result
//   side, so a request is still taken while a result waits; item_ready is low while
//   the skid stage is full and rises at the edge where the receiver takes a result
//   reset clears positions, prior samples, drop marks and clutch flags and
//   loads the register defaults; cfg_we writes a register; the user must write
//   only while the block is idle, as the block itself does not enforce it
`default_nettype none

module clutch_trigger_from_leg_motion_top #(
  parameter int CHANNELS = cltrig_pkg::CHANNELS_DEF,
  parameter int POS_BITS = cltrig_pkg::POS_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [cltrig_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cltrig_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                     item_valid,
  output logic                                     item_ready,
  input  logic                                     run,
  input  logic signed [cltrig_pkg::VEL_W-1:0]      vel_a,
  input  logic signed [cltrig_pkg::VEL_W-1:0]      vel_b,
  input  logic signed [cltrig_pkg::VEL_W-1:0]      vel_c,
  input  logic signed [cltrig_pkg::VEL_W-1:0]      vel_d,
  input  logic signed [cltrig_pkg::VEL_W-1:0]      vel_e,
  input  logic signed [cltrig_pkg::VEL_W-1:0]      vel_f,
  input  logic signed [cltrig_pkg::VEL_W-1:0]      vel_g,
  input  logic signed [cltrig_pkg::VEL_W-1:0]      vel_h,
  output logic                                     result_valid,
  input  logic                                     result_ready,
  output logic [cltrig_pkg::MAX_CH-1:0]            clutch_drive,
  output logic [cltrig_pkg::MAX_CH-1:0]            clutch_latched,
  output logic signed [cltrig_pkg::POS_OUT_W-1:0]  pos_a,
  output logic signed [cltrig_pkg::POS_OUT_W-1:0]  pos_b,
  output logic signed [cltrig_pkg::POS_OUT_W-1:0]  pos_c,
  output logic signed [cltrig_pkg::POS_OUT_W-1:0]  pos_d,
  output logic signed [cltrig_pkg::POS_OUT_W-1:0]  pos_e,
  output logic signed [cltrig_pkg::POS_OUT_W-1:0]  pos_f,
  output logic signed [cltrig_pkg::POS_OUT_W-1:0]  pos_g,
  output logic signed [cltrig_pkg::POS_OUT_W-1:0]  pos_h
);
  import cltrig_pkg::*;

  cfg_t                     cfg;
  logic                     step;
  logic signed [VEL_W-1:0]  vel_in   [MAX_CH];
  logic signed [VEL_W-1:0]  vel_link [MAX_CH];
  logic [POS_OUT_W-1:0]     pos_new  [MAX_CH];
  logic [MAX_CH-1:0]        flag_new;
  res_t                     res_new, out_res, skid_res;
  logic                     skid_valid;

  cltrig_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign vel_in[0] = vel_a;
  assign vel_in[1] = vel_b;
  assign vel_in[2] = vel_c;
  assign vel_in[3] = vel_d;
  assign vel_in[4] = vel_e;
  assign vel_in[5] = vel_f;
  assign vel_in[6] = vel_g;
  assign vel_in[7] = vel_h;

  assign item_ready = !skid_valid;
  assign step       = item_valid && item_ready;

  for (genvar g = 0; g < MAX_CH; g++) begin : g_ch
    if (g < CHANNELS) begin : g_cell
      localparam int NX = (g + 1 < CHANNELS) ? g + 1 : 0;
      logic signed [POS_OUT_W-1:0] pos_cell;
      cltrig_cell #(
        .POS_BITS (POS_BITS)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .step     (step),
        .run      (run),
        .vel      (vel_in[g]),
        .vel_next (vel_link[NX]),
        .cfg      (cfg),
        .mask_bit (cfg.drive_mask[g]),
        .vel_out  (vel_link[g]),
        .pos_res  (pos_cell),
        .flag_res (flag_new[g])
      );
      assign pos_new[g] = pos_cell;
    end else begin : g_off
      assign vel_link[g] = '0;
      assign pos_new[g]  = '0;
      assign flag_new[g] = 1'b0;
    end
    assign res_new.pos[g] = pos_new[g];
  end

  assign res_new.latched = flag_new;
  assign res_new.drive   = flag_new & cfg.drive_mask & {MAX_CH{run}};

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_ready) begin
      result_valid <= skid_valid || step;
      skid_valid   <= 1'b0;
    end else if (step) begin
      skid_valid   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      out_res <= skid_valid ? skid_res : res_new;
    end else if (step) begin
      skid_res <= res_new;
    end
  end

  assign clutch_drive   = out_res.drive;
  assign clutch_latched = out_res.latched;
  assign pos_a = out_res.pos[0];
  assign pos_b = out_res.pos[1];
  assign pos_c = out_res.pos[2];
  assign pos_d = out_res.pos[3];
  assign pos_e = out_res.pos[4];
  assign pos_f = out_res.pos[5];
  assign pos_g = out_res.pos[6];
  assign pos_h = out_res.pos[7];

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid stage holds a result while the result register is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (step && result_valid && !result_ready) |=> skid_valid)
    else $error("request taken during a stall was not kept in the skid stage");

  a_drive_within_latch: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((clutch_drive & ~clutch_latched) == '0))
    else $error("clutch driven without its latch set");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!result_valid && !skid_valid))
    else $error("result pending right after reset");

endmodule

`default_nettype wire

/* sv/cltrig_cfg.sv */
// configuration register bank for the clutch trigger block
// depends on cltrig_pkg
`default_nettype none

module cltrig_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [cltrig_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cltrig_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cltrig_pkg::cfg_t                   cfg
);
  import cltrig_pkg::*;

  cfg_t cfg_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.rev_floor  <= REV_FLOOR_RST;
      cfg_reg.eng_depth  <= ENG_DEPTH_RST;
      cfg_reg.eng_speed  <= ENG_SPEED_RST;
      cfg_reg.rel_speed  <= REL_SPEED_RST;
      cfg_reg.drive_mask <= DRIVE_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REV_FLOOR:  cfg_reg.rev_floor  <= cfg_data[23:0];
        CFG_ENG_DEPTH:  cfg_reg.eng_depth  <= cfg_data[23:0];
        CFG_ENG_SPEED:  cfg_reg.eng_speed  <= cfg_data[7:0];
        CFG_REL_SPEED:  cfg_reg.rel_speed  <= cfg_data[7:0];
        CFG_DRIVE_MASK: cfg_reg.drive_mask <= cfg_data[MAX_CH-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* sv/cltrig_cell.sv */
// one channel cell: position integrator, reversal zeroing and clutch latch
// passes its sample to the neighbouring cell for release; depends on cltrig_pkg
`default_nettype none

module cltrig_cell #(
  parameter int POS_BITS = cltrig_pkg::POS_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       step,
  input  logic                                       run,
  input  logic signed [cltrig_pkg::VEL_W-1:0]        vel,
  input  logic signed [cltrig_pkg::VEL_W-1:0]        vel_next,
  input  cltrig_pkg::cfg_t                           cfg,
  input  logic                                       mask_bit,
  output logic signed [cltrig_pkg::VEL_W-1:0]        vel_out,
  output logic signed [cltrig_pkg::POS_OUT_W-1:0]    pos_res,
  output logic                                       flag_res
);
  import cltrig_pkg::*;

  localparam int CW = (POS_BITS > POS_OUT_W) ? POS_BITS : POS_OUT_W;

  logic signed [POS_BITS-1:0] position, pos_base, pos_sat, pos_fin;
  logic signed [POS_BITS:0]   sum;
  logic signed [VEL_W-1:0]    prior_vel, prior_vel_next;
  logic                       first_dropped, first_dropped_next;
  logic                       clutch_flag, clutch_flag_next;
  logic signed [CW-1:0]       pos_cmp, floor_cmp, depth_cmp, fin_ext;
  logic                       reversal, latch, flag_mid, rel_hit;

  // first nonzero position is dropped once
  assign pos_base = (!first_dropped && position != '0) ? '0 : position;
  assign sum      = (POS_BITS+1)'(pos_base) + (POS_BITS+1)'(vel);

  always_comb begin
    if (sum[POS_BITS] != sum[POS_BITS-1]) begin
      pos_sat = sum[POS_BITS] ? {1'b1, {(POS_BITS-1){1'b0}}} : {1'b0, {(POS_BITS-1){1'b1}}};
    end else begin
      pos_sat = sum[POS_BITS-1:0];
    end
  end

  assign pos_cmp   = CW'(pos_sat);
  assign floor_cmp = CW'($signed(cfg.rev_floor));
  assign depth_cmp = CW'($signed(cfg.eng_depth));

  assign reversal = run && (prior_vel > 8'sd0) && (vel <= 8'sd0) && (pos_cmp > floor_cmp);
  assign pos_fin  = reversal ? '0 : pos_sat;
  assign fin_ext  = CW'(pos_fin);

  assign latch = run && (vel < 8'sd0) && (vel >= $signed(cfg.eng_speed)) &&
                 (vel > prior_vel) && (fin_ext < depth_cmp) && !clutch_flag;
  assign flag_mid = clutch_flag | latch;
  assign rel_hit  = run && mask_bit && flag_mid && (vel_next < $signed(cfg.rel_speed));

  assign clutch_flag_next   = flag_mid & ~rel_hit;
  assign prior_vel_next     = run ? vel : prior_vel;
  assign first_dropped_next = first_dropped | (position != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      prior_vel     <= '0;
      first_dropped <= 1'b0;
      clutch_flag   <= 1'b0;
    end else if (step) begin
      position      <= pos_fin;
      prior_vel     <= prior_vel_next;
      first_dropped <= first_dropped_next;
      clutch_flag   <= clutch_flag_next;
    end
  end

  assign vel_out  = vel;
  assign pos_res  = fin_ext[POS_OUT_W-1:0];
  assign flag_res = clutch_flag_next;

endmodule

`default_nettype wire

/* bench/tb_clutch_trigger_from_leg_motion_top.sv */
// self-checking bench for clutch_trigger_from_leg_motion_top: directed rows, gait-shaped
// random requests under several register settings, then steady ramps
// depends on cltrig_pkg and the block's rtl only
`timescale 1ns / 1ps

module tb_clutch_trigger_from_leg_motion_top;
  import cltrig_pkg::*;

  localparam int POS_HI      = 2 ** (POS_OUT_W - 1) - 1;
  localparam int POS_LO      = -(2 ** (POS_OUT_W - 1));
  localparam int PHASES      = 8;
  localparam int PHASE_TICKS = 155;
  localparam int RAMP_UP     = 60;
  localparam int RAMP_DOWN   = 120;
  localparam int LONG_HOLD   = 60;
  localparam int CYCLE_LIMIT = 100000;

  typedef struct packed {
    logic                    run;
    logic [MAX_CH-1:0][7:0]  vel;
  } tick_t;

  typedef struct packed {
    tick_t t;
    bit    pinned;
    res_t  want;
  } walk_row_t;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_EVERY_THIRD, READY_MOSTLY} stall_pattern_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic item_valid;
  logic item_ready;
  logic run;
  logic signed [VEL_W-1:0] vel_a, vel_b, vel_c, vel_d, vel_e, vel_f, vel_g, vel_h;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [MAX_CH-1:0] clutch_drive;
  logic [MAX_CH-1:0] clutch_latched;
  logic signed [POS_OUT_W-1:0] pos_a, pos_b, pos_c, pos_d, pos_e, pos_f, pos_g, pos_h;

  // predictor state and register copy
  logic signed [POS_OUT_W-1:0] leg_pos [MAX_CH];
  logic signed [VEL_W-1:0]     last_vel [MAX_CH];
  bit                          drop_done [MAX_CH];
  bit                          clutch_on [MAX_CH];
  logic signed [23:0]          floor_cfg, depth_cfg;
  logic signed [VEL_W-1:0]     speed_min_cfg, rel_cfg;
  logic [MAX_CH-1:0]           mask_cfg;

  res_t      tick_results [$];
  walk_row_t walk_rows [$];
  bit        pin_on;
  res_t      pin_want;
  int        mismatches;
  int        burst_left;
  bit        steady;
  int        stride_kind [MAX_CH];
  int        stride_left [MAX_CH];
  int        stride_peak [MAX_CH];

  bit             hold_request;
  int             hold_left;
  int             mode_left;
  int             pattern_step;
  int             cycle_count;
  stall_pattern_t stall_mode;

  string pos_names [MAX_CH] = '{"pos_a", "pos_b", "pos_c", "pos_d",
                                "pos_e", "pos_f", "pos_g", "pos_h"};

  clutch_trigger_from_leg_motion_top u_top (.*);

  always #2 clk = ~clk;

  task automatic advance_legs(input tick_t t, output res_t r);
    logic signed [VEL_W-1:0] v [MAX_CH];
    int acc;
    int nx;
    r = '0;
    for (int i = 0; i < MAX_CH; i++) begin
      v[i] = t.vel[i];
      if (!drop_done[i] && leg_pos[i] != 0) begin
        leg_pos[i] = '0;
        drop_done[i] = 1'b1;
      end
      acc = int'(leg_pos[i]) + int'(v[i]);
      if (acc > POS_HI) begin
        acc = POS_HI;
      end else if (acc < POS_LO) begin
        acc = POS_LO;
      end
      leg_pos[i] = acc[POS_OUT_W-1:0];
    end
    if (t.run) begin
      for (int i = 0; i < MAX_CH; i++) begin
        if (last_vel[i] > 0 && v[i] <= 0 && leg_pos[i] > floor_cfg) leg_pos[i] = '0;
      end
      for (int i = 0; i < MAX_CH; i++) begin
        if (v[i] < 0 && v[i] >= speed_min_cfg && v[i] > last_vel[i] && leg_pos[i] < depth_cfg)
          clutch_on[i] = 1'b1;
        last_vel[i] = v[i];
      end
      // ring order: the last channel is released by the first
      for (int i = 0; i < MAX_CH; i++) begin
        nx = (i + 1) % MAX_CH;
        if (mask_cfg[i] && clutch_on[i] && v[nx] < rel_cfg) clutch_on[i] = 1'b0;
      end
    end
    for (int i = 0; i < MAX_CH; i++) begin
      r.latched[i] = clutch_on[i];
      r.drive[i] = clutch_on[i] & t.run & mask_cfg[i];
      r.pos[i] = leg_pos[i];
    end
  endtask

  // swing, slowing stance or noise per channel
  function automatic tick_t gait_tick();
    tick_t t;
    int mag;
    t.run = ($urandom_range(0, 9) != 0);
    for (int i = 0; i < MAX_CH; i++) begin
      if (stride_left[i] == 0) begin
        stride_kind[i] = $urandom_range(0, 19);
        stride_left[i] = $urandom_range(2, 12);
        stride_peak[i] = $urandom_range(4, 127);
      end
      stride_left[i]--;
      if (stride_kind[i] < 8) begin
        t.vel[i] = 8'($urandom_range(1, stride_peak[i]));
      end else if (stride_kind[i] < 17) begin
        mag = stride_peak[i] * stride_left[i] / 12 + $urandom_range(1, 2);
        t.vel[i] = 8'(-mag);
      end else begin
        t.vel[i] = 8'($urandom_range(0, 255));
      end
    end
    return t;
  endfunction

  task automatic check_field(input string name, input logic [POS_OUT_W-1:0] want_v,
                             input logic [POS_OUT_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %h, got %h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  task automatic add_row(input bit r, input logic [63:0] lanes, input bit pinned,
                         input logic [7:0] drv, input logic [7:0] lat, input int pos_all);
    walk_row_t w;
    w.t.run = r;
    w.t.vel = lanes;
    w.pinned = pinned;
    w.want.drive = drv;
    w.want.latched = lat;
    for (int i = 0; i < MAX_CH; i++) w.want.pos[i] = pos_all[POS_OUT_W-1:0];
    walk_rows.push_back(w);
  endtask

  task automatic offer_tick(input tick_t t, input bit pinned, input res_t want_r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    pin_on = pinned;
    pin_want = want_r;
    item_valid <= 1'b1;
    run <= t.run;
    vel_a <= t.vel[0];
    vel_b <= t.vel[1];
    vel_c <= t.vel[2];
    vel_d <= t.vel[3];
    vel_e <= t.vel[4];
    vel_f <= t.vel[5];
    vel_g <= t.vel[6];
    vel_h <= t.vel[7];
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (tick_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_REV_FLOOR:  floor_cfg = data;
      CFG_ENG_DEPTH:  depth_cfg = data;
      CFG_ENG_SPEED:  speed_min_cfg = data[VEL_W-1:0];
      CFG_REL_SPEED:  rel_cfg = data[VEL_W-1:0];
      CFG_DRIVE_MASK: mask_cfg = data[MAX_CH-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // result check first, then predict for the request taken at this edge
  always @(posedge clk) begin
    res_t want;
    res_t got;
    tick_t seen;
    if (!rst) begin
      if (result_valid && result_ready) begin
        got.drive = clutch_drive;
        got.latched = clutch_latched;
        got.pos[0] = pos_a;
        got.pos[1] = pos_b;
        got.pos[2] = pos_c;
        got.pos[3] = pos_d;
        got.pos[4] = pos_e;
        got.pos[5] = pos_f;
        got.pos[6] = pos_g;
        got.pos[7] = pos_h;
        if (tick_results.size() == 0) begin
          $error("result with no request pending");
          mismatches++;
        end else begin
          want = tick_results.pop_front();
          check_field("clutch_drive", POS_OUT_W'(want.drive), POS_OUT_W'(got.drive));
          check_field("clutch_latched", POS_OUT_W'(want.latched), POS_OUT_W'(got.latched));
          for (int i = 0; i < MAX_CH; i++) check_field(pos_names[i], want.pos[i], got.pos[i]);
        end
      end
      if (item_valid && item_ready) begin
        seen.run = run;
        seen.vel[0] = vel_a;
        seen.vel[1] = vel_b;
        seen.vel[2] = vel_c;
        seen.vel[3] = vel_d;
        seen.vel[4] = vel_e;
        seen.vel[5] = vel_f;
        seen.vel[6] = vel_g;
        seen.vel[7] = vel_h;
        advance_legs(seen, want);
        tick_results.push_back(pin_on ? pin_want : want);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (mode_left == 0) begin
      stall_mode = stall_pattern_t'($urandom_range(0, 3));
      mode_left = $urandom_range(32, 256);
    end
    mode_left--;
    pattern_step++;
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      case (stall_mode)
        READY_ALWAYS: result_ready <= 1'b1;
        READY_COIN: begin
          result_ready <= ($urandom_range(0, 1) != 0);
          if ($urandom_range(0, 499) == 0) hold_left = $urandom_range(10, 40);
        end
        READY_EVERY_THIRD: result_ready <= (pattern_step % 3 == 0);
        default: result_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    tick_t t;
    logic [23:0] floor_v, depth_v;
    logic [7:0] spd_v, rel_v, mask_v;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_REV_FLOOR;
    cfg_data = '0;
    item_valid = 1'b0;
    run = 1'b0;
    {vel_a, vel_b, vel_c, vel_d, vel_e, vel_f, vel_g, vel_h} = '0;
    floor_cfg = REV_FLOOR_RST;
    depth_cfg = ENG_DEPTH_RST;
    speed_min_cfg = ENG_SPEED_RST;
    rel_cfg = REL_SPEED_RST;
    mask_cfg = DRIVE_MASK_RST;
    for (int i = 0; i < MAX_CH; i++) begin
      leg_pos[i] = '0;
      last_vel[i] = '0;
      drop_done[i] = 1'b0;
      clutch_on[i] = 1'b0;
    end

    // reset values: floor -50, depth -60, speed -6, release -5, mask fc
    add_row(1'b1, {8{8'h00}}, 1'b1, 8'h00, 8'h00, 0);
    add_row(1'b1, {8{8'h7F}}, 1'b1, 8'h00, 8'h00, 127);
    // first nonzero position is dropped before the add
    add_row(1'b1, {8{8'h80}}, 1'b1, 8'h00, 8'h00, -128);
    add_row(1'b1, {8{8'hFD}}, 1'b1, 8'hFC, 8'hFF, -131);
    // stopped: integrate only, drive low
    add_row(1'b0, {8{8'h80}}, 1'b1, 8'h00, 8'hFF, -259);
    // masked channels release, unmasked ones hold
    add_row(1'b1, {8{8'h9C}}, 1'b1, 8'h00, 8'h03, -359);
    add_row(1'b1, {8{8'h05}}, 1'b0, '0, '0, 0);
    add_row(1'b1, {8{8'h7F}}, 1'b0, '0, '0, 0);
    add_row(1'b1, {8{8'h7F}}, 1'b0, '0, '0, 0);
    add_row(1'b1, {8{8'h7F}}, 1'b0, '0, '0, 0);
    // reversal above the floor
    add_row(1'b1, {8{8'hFF}}, 1'b0, '0, '0, 0);
    add_row(1'b1, {8{8'h9C}}, 1'b0, '0, '0, 0);
    // latch and release in the same tick
    add_row(1'b1, {4{8'h9C, 8'hFD}}, 1'b0, '0, '0, 0);
    add_row(1'b1, {8{8'hFD}}, 1'b0, '0, '0, 0);
    // last channel released by the first
    add_row(1'b1, {56'h0, 8'hCE}, 1'b0, '0, '0, 0);
    add_row(1'b1, 64'h7F80_01FE_55AA_00FF, 1'b0, '0, '0, 0);
    add_row(1'b0, 64'h80FF_7F00_AA55_FE01, 1'b0, '0, '0, 0);
    add_row(1'b1, {8{8'hFA}}, 1'b0, '0, '0, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (walk_rows[n]) offer_tick(walk_rows[n].t, walk_rows[n].pinned, walk_rows[n].want);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          floor_v = REV_FLOOR_RST; depth_v = ENG_DEPTH_RST;
          spd_v = ENG_SPEED_RST; rel_v = REL_SPEED_RST; mask_v = DRIVE_MASK_RST;
        end
        1: begin
          floor_v = 24'h7FFFFF; depth_v = 24'h7FFFFF;
          spd_v = 8'h80; rel_v = 8'h7F; mask_v = 8'hFF;
        end
        2: begin
          floor_v = 24'h800000; depth_v = 24'h800000;
          spd_v = 8'h7F; rel_v = 8'h80; mask_v = 8'h00;
        end
        3: begin
          floor_v = 24'h000000; depth_v = 24'h000000;
          spd_v = 8'hFF; rel_v = 8'hFF; mask_v = 8'h55;
        end
        4: begin
          floor_v = 24'hFFFFEC; depth_v = 24'h000028;
          spd_v = 8'hEC; rel_v = 8'hE2; mask_v = 8'hAA;
        end
        default: begin
          floor_v = 24'(int'($urandom_range(0, 600)) - 450);
          depth_v = 24'(int'($urandom_range(0, 500)) - 400);
          spd_v = 8'(int'($urandom_range(0, 40)) - 40);
          rel_v = 8'(int'($urandom_range(0, 80)) - 70);
          mask_v = 8'($urandom_range(0, 255));
        end
      endcase
      write_reg(CFG_REV_FLOOR, floor_v);
      write_reg(CFG_ENG_DEPTH, depth_v);
      write_reg(CFG_ENG_SPEED, {16'($urandom), spd_v});
      write_reg(CFG_REL_SPEED, {16'($urandom), rel_v});
      write_reg(CFG_DRIVE_MASK, {16'($urandom), mask_v});
      write_reg(CFG_IDX_W'(CFG_DRIVE_MASK + 1 + $urandom_range(0, 2)), 24'($urandom));
      cfg_we <= 1'b0;
      if (p == 0 || p == 4) hold_request = 1'b1;
      repeat (PHASE_TICKS) offer_tick(gait_tick(), 1'b0, '0);
      settle();
    end

    // steady ramp up, then down while stopped
    steady = 1'b1;
    t.run = 1'b1;
    t.vel = {8{8'h7F}};
    repeat (RAMP_UP) offer_tick(t, 1'b0, '0);
    t.run = 1'b0;
    t.vel = {8{8'h80}};
    repeat (RAMP_DOWN) offer_tick(t, 1'b0, '0);
    steady = 1'b0;
    repeat (4) offer_tick(gait_tick(), 1'b0, '0);
    settle();
    repeat (4) @(negedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
